### src/spq_pkg.sv
package spq_pkg;

  // default sizes of the item store
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_PRIORITY_BITS = 8;
  localparam int DEF_TAG_BITS      = 16;

  // fixed widths of the stream fields
  localparam int PRIO_FIELD_W  = 8;
  localparam int TAG_FIELD_W   = 16;
  localparam int FILL_FIELD_W  = 5;
  localparam int STAT_FIELD_W  = 2;

  // input beat: tdata = priority_req, item_tag
  localparam int IN_TDATA_W = 24;
  localparam int IN_TUSER_W = 1;

  // output beat: tdata = head_valid, head_tag, tail_valid, tail_tag, fill_count, status
  localparam int OUT_HEAD_VALID_POS = 0;
  localparam int OUT_HEAD_TAG_LSB   = 1;
  localparam int OUT_TAIL_VALID_POS = 17;
  localparam int OUT_TAIL_TAG_LSB   = 18;
  localparam int OUT_FILL_LSB       = 34;
  localparam int OUT_STAT_LSB       = 39;
  localparam int OUT_USED_W         = 41;
  localparam int OUT_TDATA_W        = 48;

  // request kinds
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  // result status codes
  typedef enum logic [STAT_FIELD_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
  } spq_cmd_t;

endpackage

### src/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output spq_pkg::spq_cmd_t cmd
);

  spq_pkg::ctrl_state_t state, state_next;
  logic                 out_valid, out_valid_next;

  // state and result flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = spq_pkg::ST_EXEC;
      end
      spq_pkg::ST_EXEC: begin
        if (!out_valid || m_tready) state_next = spq_pkg::ST_IDLE;
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    s_tready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.exec     = 1'b0;
    case (state)
      spq_pkg::ST_IDLE: begin
        s_tready     = 1'b1;
        cmd.load_req = s_tvalid;
      end
      spq_pkg::ST_EXEC: begin
        cmd.exec = !out_valid || m_tready;
      end
      default: ;
    endcase
  end

  // result held until the downstream side takes the beat
  always_comb begin
    if (cmd.exec) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  assign m_tvalid = out_valid;

endmodule

### src/spq_datapath.sv
module spq_datapath #(
  parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
  parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::spq_cmd_t                cmd,
  input  logic [spq_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic [spq_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic [spq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PF    = spq_pkg::PRIO_FIELD_W;
  localparam int TF    = spq_pkg::TAG_FIELD_W;
  localparam int FF    = spq_pkg::FILL_FIELD_W;

  // latched request
  logic                     req_remove;
  logic [PRIORITY_BITS-1:0] req_prio;
  logic [TAG_BITS-1:0]      req_tag;

  // cell row, slot 0 is the head
  logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      cell_tag  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio_next [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      cell_tag_next  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prev_prio [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      prev_tag  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] up_prio   [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      up_tag    [QUEUE_DEPTH];

  logic [CNT_W-1:0]    count, count_next;
  logic [TAG_BITS-1:0] tail, tail_next;

  logic [QUEUE_DEPTH-1:0] occ, le, le_sh;
  logic                   full, empty, ins_ok, rem_ok, all_le;
  spq_pkg::stat_t         stat;

  // field fitting
  logic [PRIORITY_BITS+PF-1:0] prio_ext;
  logic [TAG_BITS+TF-1:0]      tag_ext;
  logic [TAG_BITS+TF-1:0]      head_ext, tail_ext;
  logic [CNT_W+FF-1:0]         fill_ext;
  logic                        head_valid;
  logic [TF-1:0]               head_out, tail_out;

  // request register
  assign prio_ext = {{PRIORITY_BITS{1'b0}}, s_tdata[PF-1:0]};
  assign tag_ext  = {{TAG_BITS{1'b0}}, s_tdata[PF+TF-1:PF]};

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_remove <= (s_tuser[0] == spq_pkg::REQ_REMOVE);
      req_prio   <= prio_ext[PRIORITY_BITS-1:0];
      req_tag    <= tag_ext[TAG_BITS-1:0];
    end
  end

  // per-cell compare against the new priority
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i] = CNT_W'(i) < count;
      le[i]  = occ[i] && (cell_prio[i] <= req_prio);
    end
  end

  assign le_sh  = {le[QUEUE_DEPTH-2:0], 1'b1};
  assign all_le = ~|(occ ^ le);
  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign ins_ok = !req_remove && !full;
  assign rem_ok = req_remove && !empty;

  // neighbour values for shifting down and up
  always_comb begin
    prev_prio[0] = req_prio;
    prev_tag[0]  = req_tag;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      prev_prio[i] = cell_prio[i-1];
      prev_tag[i]  = cell_tag[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      up_prio[i] = cell_prio[i+1];
      up_tag[i]  = cell_tag[i+1];
    end
    up_prio[QUEUE_DEPTH-1] = cell_prio[QUEUE_DEPTH-1];
    up_tag[QUEUE_DEPTH-1]  = cell_tag[QUEUE_DEPTH-1];
  end

  // cell update: keep, take the new item, or shift
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_prio_next[i] = cell_prio[i];
      cell_tag_next[i]  = cell_tag[i];
      if (ins_ok && !le[i]) begin
        if (le_sh[i]) begin
          cell_prio_next[i] = req_prio;
          cell_tag_next[i]  = req_tag;
        end else begin
          cell_prio_next[i] = prev_prio[i];
          cell_tag_next[i]  = prev_tag[i];
        end
      end else if (rem_ok) begin
        cell_prio_next[i] = up_prio[i];
        cell_tag_next[i]  = up_tag[i];
      end
    end
  end

  // count, tail and status
  always_comb begin
    count_next = count;
    tail_next  = tail;
    stat       = spq_pkg::STAT_OK;
    if (ins_ok) begin
      count_next = count + 1'b1;
      if (all_le) tail_next = req_tag;
    end else if (rem_ok) begin
      count_next = count - 1'b1;
    end else if (req_remove) begin
      stat = spq_pkg::STAT_EMPTY;
    end else begin
      stat = spq_pkg::STAT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        cell_prio[i] <= cell_prio_next[i];
        cell_tag[i]  <= cell_tag_next[i];
      end
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.exec) count <= count_next;
  end

  // result fields
  assign head_valid = (count_next != '0);
  assign head_ext   = {{TF{1'b0}}, cell_tag_next[0]};
  assign tail_ext   = {{TF{1'b0}}, tail_next};
  assign fill_ext   = {{FF{1'b0}}, count_next};
  assign head_out   = head_valid ? head_ext[TF-1:0] : '0;
  assign tail_out   = head_valid ? tail_ext[TF-1:0] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      m_tdata <= {{(spq_pkg::OUT_TDATA_W - spq_pkg::OUT_USED_W){1'b0}},
                  stat, fill_ext[FF-1:0], tail_out, head_valid, head_out, head_valid};
    end
  end

endmodule

### src/stable_priority_queue_top.sv
// Stable priority queue of up to QUEUE_DEPTH tagged items in ascending priority order; a lower
// number is served first and equal priorities leave in arrival order. Each request beat (tuser 0
// insert, 1 remove head) gives one result beat with the head and tail tags, their valid flags, the
// fill count and a status (ok, insert dropped because full, remove on empty). A request is taken
// in the idle state; then, in the exec state, the whole cell row compares and shifts at once;
// the controller takes one request at a time, and a result left waiting on the output holds the
// next request in its update cycle until the beat is taken. No clearing pass follows reset.
module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
  parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // priority_req [7:0], item_tag [23:8]
  input  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // req_type [0]
  input  logic [spq_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // head_valid [0], head_tag [16:1], tail_valid [17], tail_tag [33:18],
  // fill_count [38:34], status [40:39]
  output logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata
);

  spq_pkg::spq_cmd_t cmd;

  // sequencing
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // cell row and result register
  spq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule

### src/spq_checker.sv
module spq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in work");

  // head and tail valid flags agree
  a_valid_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[spq_pkg::OUT_HEAD_VALID_POS] == m_tdata[spq_pkg::OUT_TAIL_VALID_POS])
    else $error("head and tail valid flags differ");

  // empty queue shows zero tags and zero fill
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[spq_pkg::OUT_HEAD_VALID_POS] |->
      m_tdata[spq_pkg::OUT_FILL_LSB-1:spq_pkg::OUT_HEAD_TAG_LSB] == '0 &&
      m_tdata[spq_pkg::OUT_STAT_LSB-1:spq_pkg::OUT_FILL_LSB] == '0)
    else $error("empty queue shows stale fields");

  // status code is never the unused value
  a_stat_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[spq_pkg::OUT_USED_W-1:spq_pkg::OUT_STAT_LSB] != 2'd3)
    else $error("unused status code");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/stable_priority_queue_top_test.sv
`timescale 1ns / 100ps

module stable_priority_queue_top_test;

  localparam int DEPTH       = spq_pkg::DEF_QUEUE_DEPTH;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 85;
  localparam int CHUNK_ITEMS = 20;

  // one result beat split into its fields
  typedef struct {
    logic                             head_valid;
    logic [spq_pkg::TAG_FIELD_W-1:0]  head_tag;
    logic                             tail_valid;
    logic [spq_pkg::TAG_FIELD_W-1:0]  tail_tag;
    logic [spq_pkg::FILL_FIELD_W-1:0] fill_count;
    spq_pkg::stat_t                   status;
  } queue_report_t;

  // sorted shadow store and the reports it predicts
  class queue_scoreboard;
    logic [spq_pkg::PRIO_FIELD_W-1:0] prio_store[DEPTH];
    logic [spq_pkg::TAG_FIELD_W-1:0]  tag_store[DEPTH];
    int unsigned                      fill = 0;
    queue_report_t                    pending[$];
    int                               errors = 0;
    int                               checked = 0;
    int                               inserts = 0;
    int                               removes = 0;
    int                               full_drops = 0;
    int                               empty_removes = 0;
    int unsigned                      peak_fill = 0;

    // apply an accepted request beat to the shadow store and queue its report
    function void note_request(spq_pkg::req_t kind, logic [spq_pkg::PRIO_FIELD_W-1:0] prio,
                               logic [spq_pkg::TAG_FIELD_W-1:0] tag);
      queue_report_t want;
      int unsigned   pos;
      want.status = spq_pkg::STAT_OK;
      if (kind == spq_pkg::REQ_INSERT) begin
        inserts++;
        if (fill >= DEPTH) begin
          want.status = spq_pkg::STAT_FULL;
          full_drops++;
        end else begin
          // new item goes behind every item of equal or lower number
          pos = 0;
          while (pos < fill && prio_store[pos] <= prio) pos++;
          for (int unsigned i = fill; i > pos; i--) begin
            prio_store[i] = prio_store[i-1];
            tag_store[i]  = tag_store[i-1];
          end
          prio_store[pos] = prio;
          tag_store[pos]  = tag;
          fill++;
        end
      end else begin
        removes++;
        if (fill == 0) begin
          want.status = spq_pkg::STAT_EMPTY;
          empty_removes++;
        end else begin
          for (int unsigned i = 0; i + 1 < fill; i++) begin
            prio_store[i] = prio_store[i+1];
            tag_store[i]  = tag_store[i+1];
          end
          fill--;
        end
      end
      if (fill > peak_fill) peak_fill = fill;
      want.head_valid = (fill != 0);
      want.tail_valid = (fill != 0);
      want.head_tag   = (fill != 0) ? tag_store[0] : '0;
      want.tail_tag   = (fill != 0) ? tag_store[fill-1] : '0;
      want.fill_count = fill[spq_pkg::FILL_FIELD_W-1:0];
      pending.push_back(want);
    endfunction

    function void report(string field, logic [spq_pkg::TAG_FIELD_W-1:0] want,
                         logic [spq_pkg::TAG_FIELD_W-1:0] got);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    endfunction

    // compare one result beat with the oldest queued report
    function void check_result(logic [spq_pkg::OUT_TDATA_W-1:0] beat);
      queue_report_t want;
      queue_report_t got;
      got.head_valid = beat[spq_pkg::OUT_HEAD_VALID_POS];
      got.head_tag   = beat[spq_pkg::OUT_HEAD_TAG_LSB +: spq_pkg::TAG_FIELD_W];
      got.tail_valid = beat[spq_pkg::OUT_TAIL_VALID_POS];
      got.tail_tag   = beat[spq_pkg::OUT_TAIL_TAG_LSB +: spq_pkg::TAG_FIELD_W];
      got.fill_count = beat[spq_pkg::OUT_FILL_LSB +: spq_pkg::FILL_FIELD_W];
      got.status     = spq_pkg::stat_t'(beat[spq_pkg::OUT_STAT_LSB +: spq_pkg::STAT_FIELD_W]);
      if (pending.size() == 0) begin
        $display("%0t: result beat 0x%0h with no request outstanding", $time, beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.head_valid !== want.head_valid)
        report("head_valid", want.head_valid, got.head_valid);
      if (got.head_tag !== want.head_tag)
        report("head_tag", want.head_tag, got.head_tag);
      if (got.tail_valid !== want.tail_valid)
        report("tail_valid", want.tail_valid, got.tail_valid);
      if (got.tail_tag !== want.tail_tag)
        report("tail_tag", want.tail_tag, got.tail_tag);
      if (got.fill_count !== want.fill_count)
        report("fill_count", want.fill_count, got.fill_count);
      if (got.status !== want.status)
        report("status", want.status, got.status);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  // priority_req [7:0], item_tag [23:8]
  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata;
  // req_type [0]
  logic [spq_pkg::IN_TUSER_W-1:0]  s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  // head_valid [0], head_tag [16:1], tail_valid [17], tail_tag [33:18],
  // fill_count [38:34], status [40:39]
  logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata;

  queue_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_req = 0;

  stable_priority_queue_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitor: requests feed the predictor, results are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_request(spq_pkg::req_t'(s_tuser[0]), s_tdata[spq_pkg::PRIO_FIELD_W-1:0],
                        s_tdata[spq_pkg::PRIO_FIELD_W +: spq_pkg::TAG_FIELD_W]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin : receiver
    int left;
    int hold_seen;
    left = 0;
    hold_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        left      = HOLD_CYCLES;
        hold_seen = hold_req;
      end
      if (left > 0) begin
        left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // offer one request beat, with a random gap first, and wait until taken
  task automatic send_request(spq_pkg::req_t kind, logic [spq_pkg::PRIO_FIELD_W-1:0] prio,
                              logic [spq_pkg::TAG_FIELD_W-1:0] tag);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tag, prio};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // random request; priorities often crowd into a few values to force ties
  task automatic random_request(int insert_pct);
    spq_pkg::req_t                    kind;
    logic [spq_pkg::PRIO_FIELD_W-1:0] prio;
    kind = ($urandom_range(99) < insert_pct) ? spq_pkg::REQ_INSERT : spq_pkg::REQ_REMOVE;
    if ($urandom_range(1) == 0) prio = spq_pkg::PRIO_FIELD_W'($urandom_range(3));
    else prio = spq_pkg::PRIO_FIELD_W'($urandom_range(255));
    send_request(kind, prio, spq_pkg::TAG_FIELD_W'($urandom));
  endtask

  // stop offering and wait until every outstanding report has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin : main
    int idle_plan[4];
    int stall_plan[4];
    int bias_plan[5];
    logic [spq_pkg::PRIO_FIELD_W-1:0] fill_prio[7];
    int bias;
    idle_plan  = '{0, 82, 0, 18};
    stall_plan = '{0, 0, 82, 18};
    bias_plan  = '{85, 50, 15, 70, 30};
    fill_prio  = '{8'h01, 8'h7f, 8'hfe, 8'h55, 8'haa, 8'h80, 8'h40};
    sb = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty remove, extremes, ties, fill to full, overflow, partial drain
    send_request(spq_pkg::REQ_REMOVE, 8'h00, 16'h0000);
    send_request(spq_pkg::REQ_INSERT, 8'hff, 16'hffff);
    send_request(spq_pkg::REQ_INSERT, 8'h00, 16'h0000);
    send_request(spq_pkg::REQ_INSERT, 8'h80, 16'h5555);
    send_request(spq_pkg::REQ_INSERT, 8'h80, 16'haaaa);
    send_request(spq_pkg::REQ_INSERT, 8'h80, 16'h0001);
    send_request(spq_pkg::REQ_INSERT, 8'h80, 16'h0002);
    send_request(spq_pkg::REQ_INSERT, 8'hff, 16'h8000);
    send_request(spq_pkg::REQ_INSERT, 8'h00, 16'h7fff);
    for (int i = 0; i < 7; i++)
      send_request(spq_pkg::REQ_INSERT, fill_prio[i], spq_pkg::TAG_FIELD_W'(16'h0100 + i));
    send_request(spq_pkg::REQ_INSERT, 8'h00, 16'h1234);
    send_request(spq_pkg::REQ_INSERT, 8'hff, 16'hfedc);
    repeat (5) send_request(spq_pkg::REQ_REMOVE, 8'hff, 16'hffff);
    send_request(spq_pkg::REQ_INSERT, 8'h80, 16'hc3c3);

    // pause until all reports are in, then back up the result side
    wait_drained();
    hold_req = hold_req + 1;
    repeat (40) random_request(60);
    wait_drained();

    // random traffic under each idling pattern, with fill and drain trends
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % CHUNK_ITEMS == 0) bias = bias_plan[$urandom_range(4)];
        random_request(bias);
      end
    end

    // wind down
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d inserts and %0d removes, %0d reports checked, peak fill %0d",
             sb.inserts, sb.removes, sb.checked, sb.peak_fill);
    $display("dropped inserts on full queue: %0d, removes on empty queue: %0d",
             sb.full_drops, sb.empty_removes);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue_top.sv
src/spq_checker.sv
bench/stable_priority_queue_top_test.sv
